@@ hw/rtl/rc4_pkg.sv @@
`timescale 1ns / 1ps

package rc4_pkg;

	localparam int PERM_DEPTH = 256;
	localparam int MAX_KEY_BYTES_DEF = 256;
	localparam logic [8:0] KEY_LENGTH_RESET = 9'd16;

	localparam logic [1:0] KIND_KEY   = 2'd0;
	localparam logic [1:0] KIND_SCHED = 2'd1;
	localparam logic [1:0] KIND_DATA  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_KS_RD,
		ST_KS_ACC,
		ST_KS_WR_K,
		ST_KS_WR_A,
		ST_PR_I,
		ST_PR_J,
		ST_PR_WR_I,
		ST_PR_WR_J,
		ST_PR_RD,
		ST_PR_XOR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       we;
		logic [7:0] waddr;
		logic [7:0] wdata;
		logic [7:0] raddr;
	} perm_req_t;

endpackage

@@ hw/rtl/rc4_if.sv @@
`timescale 1ns / 1ps

interface rc4_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] key_index;
	logic [7:0] key_byte;
	logic [7:0] data_in;
	logic       last_byte;

	modport source (output valid, kind, key_index, key_byte, data_in, last_byte, input ready);
	modport sink (input valid, kind, key_index, key_byte, data_in, last_byte, output ready);
endinterface

interface rc4_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;
	logic       schedule_done;
	logic       last_out;

	modport source (output valid, data_out, schedule_done, last_out, input ready);
	modport sink (input valid, data_out, schedule_done, last_out, output ready);
endinterface

@@ hw/rtl/rc4_stream_cipher_top.sv @@
`timescale 1ns / 1ps

// port        dir  handshake         content
// cmd         in   valid/ready       kind, key_index, key_byte, data_in, last_byte
// res         out  valid/ready       data_out, schedule_done, last_out
// cfg_we/wd   in   write enable      key_length, 9 bits
//
// key byte beat: written into the key store on acceptance, if key_index < MAX_KEY_BYTES
// data beat: states PR_I, PR_J, PR_WR_I, PR_WR_J, PR_RD, PR_XOR, then the result beat in DONE
// key schedule: INIT fills the ram, then a KS_RD, KS_ACC, KS_WR_K, KS_WR_A swap per entry, then the done beat
// one beat in flight; after a schedule or data beat cmd.ready is low until the result beat is taken
// arst_n clears control, indices and key_length (16); rams are not cleared

module rc4_stream_cipher_top #(
	parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF,
	localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
	input  logic       clk,
	input  logic       arst_n,
	rc4_in_if.sink     cmd,
	rc4_out_if.source  res,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata
);

	logic [8:0]         key_length_q;
	rc4_pkg::perm_req_t perm_req;
	logic [7:0]         perm_rdata;
	logic               key_we;
	logic [KEY_AW-1:0]  key_waddr;
	logic [7:0]         key_wdata;
	logic [KEY_AW-1:0]  key_raddr;
	logic [7:0]         key_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= rc4_pkg::KEY_LENGTH_RESET;
		end else if (cfg_we) begin
			key_length_q <= cfg_wdata;
		end
	end

	rc4_core #(
		.MAX_KEY_BYTES(MAX_KEY_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.res        (res),
		.key_length (key_length_q),
		.perm_req   (perm_req),
		.perm_rdata (perm_rdata),
		.key_we     (key_we),
		.key_waddr  (key_waddr),
		.key_wdata  (key_wdata),
		.key_raddr  (key_raddr),
		.key_rdata  (key_rdata)
	);

	rc4_ram #(
		.WIDTH(8),
		.DEPTH(rc4_pkg::PERM_DEPTH)
	) u_perm_ram (
		.clk   (clk),
		.we    (perm_req.we),
		.waddr (perm_req.waddr),
		.wdata (perm_req.wdata),
		.raddr (perm_req.raddr),
		.rdata (perm_rdata)
	);

	rc4_ram #(
		.WIDTH(8),
		.DEPTH(MAX_KEY_BYTES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

endmodule

@@ hw/rtl/rc4_ram.sv @@
`timescale 1ns / 1ps

module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/rc4_core.sv @@
`timescale 1ns / 1ps

module rc4_core #(
	parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF,
	localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	rc4_in_if.sink              cmd,
	rc4_out_if.source           res,
	input  logic [8:0]          key_length,
	output rc4_pkg::perm_req_t  perm_req,
	input  logic [7:0]          perm_rdata,
	output logic                key_we,
	output logic [KEY_AW-1:0]   key_waddr,
	output logic [7:0]          key_wdata,
	output logic [KEY_AW-1:0]   key_raddr,
	input  logic [7:0]          key_rdata
);

	rc4_pkg::state_t state_q, state_d;

	logic [7:0]        cnt_q;
	logic [KEY_AW-1:0] kpos_q;
	logic [7:0]        i_q;
	logic [7:0]        j_q;
	logic [7:0]        acc_q;
	logic [7:0]        pa_q;
	logic [7:0]        pb_q;
	logic [7:0]        din_q;
	logic              last_q;
	logic [7:0]        res_data_q;
	logic              res_done_q;
	logic              res_last_q;

	logic [8:0]        klen;
	logic [KEY_AW-1:0] kpos_last;
	logic [7:0]        op_a;
	logic [7:0]        op_b;
	logic [7:0]        op_c;
	logic [7:0]        sum;
	logic              accept;

	assign accept = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == rc4_pkg::ST_IDLE);

	assign res.valid = (state_q == rc4_pkg::ST_DONE);
	assign res.data_out = res_data_q;
	assign res.schedule_done = res_done_q;
	assign res.last_out = res_last_q;

	// key store write straight from the input beat
	assign key_we = accept && (cmd.kind == rc4_pkg::KIND_KEY)
		&& ({1'b0, cmd.key_index} < 9'(MAX_KEY_BYTES));
	assign key_waddr = KEY_AW'(cmd.key_index);
	assign key_wdata = cmd.key_byte;
	assign key_raddr = kpos_q;

	always_comb begin
		if (key_length == 9'd0) begin
			klen = 9'd1;
		end else if (key_length > 9'(MAX_KEY_BYTES)) begin
			klen = 9'(MAX_KEY_BYTES);
		end else begin
			klen = key_length;
		end
	end

	assign kpos_last = KEY_AW'(klen - 9'd1);

	// shared byte adder
	always_comb begin
		op_a = '0;
		op_b = '0;
		op_c = '0;
		case (state_q)
			rc4_pkg::ST_KS_ACC: begin
				op_a = acc_q;
				op_b = perm_rdata;
				op_c = key_rdata;
			end
			rc4_pkg::ST_PR_I: begin
				op_a = i_q;
				op_b = 8'd1;
			end
			rc4_pkg::ST_PR_J: begin
				op_a = j_q;
				op_b = perm_rdata;
			end
			rc4_pkg::ST_PR_WR_J: begin
				op_a = pa_q;
				op_b = pb_q;
			end
			default: begin
			end
		endcase
	end

	assign sum = op_a + op_b + op_c;

	always_comb begin
		state_d = state_q;
		perm_req = '0;
		case (state_q)
			rc4_pkg::ST_IDLE: begin
				if (accept) begin
					case (cmd.kind)
						rc4_pkg::KIND_SCHED: state_d = rc4_pkg::ST_INIT;
						rc4_pkg::KIND_DATA:  state_d = rc4_pkg::ST_PR_I;
						default:             state_d = rc4_pkg::ST_IDLE;
					endcase
				end
			end
			rc4_pkg::ST_INIT: begin
				perm_req.we = 1'b1;
				perm_req.waddr = cnt_q;
				perm_req.wdata = cnt_q;
				if (cnt_q == 8'hff) begin
					state_d = rc4_pkg::ST_KS_RD;
				end
			end
			rc4_pkg::ST_KS_RD: begin
				perm_req.raddr = cnt_q;
				state_d = rc4_pkg::ST_KS_ACC;
			end
			rc4_pkg::ST_KS_ACC: begin
				perm_req.raddr = sum;
				state_d = rc4_pkg::ST_KS_WR_K;
			end
			rc4_pkg::ST_KS_WR_K: begin
				perm_req.we = 1'b1;
				perm_req.waddr = cnt_q;
				perm_req.wdata = perm_rdata;
				state_d = rc4_pkg::ST_KS_WR_A;
			end
			rc4_pkg::ST_KS_WR_A: begin
				perm_req.we = 1'b1;
				perm_req.waddr = acc_q;
				perm_req.wdata = pa_q;
				state_d = (cnt_q == 8'hff) ? rc4_pkg::ST_DONE : rc4_pkg::ST_KS_RD;
			end
			rc4_pkg::ST_PR_I: begin
				perm_req.raddr = sum;
				state_d = rc4_pkg::ST_PR_J;
			end
			rc4_pkg::ST_PR_J: begin
				perm_req.raddr = sum;
				state_d = rc4_pkg::ST_PR_WR_I;
			end
			rc4_pkg::ST_PR_WR_I: begin
				perm_req.we = 1'b1;
				perm_req.waddr = i_q;
				perm_req.wdata = perm_rdata;
				state_d = rc4_pkg::ST_PR_WR_J;
			end
			rc4_pkg::ST_PR_WR_J: begin
				perm_req.we = 1'b1;
				perm_req.waddr = j_q;
				perm_req.wdata = pa_q;
				state_d = rc4_pkg::ST_PR_RD;
			end
			rc4_pkg::ST_PR_RD: begin
				perm_req.raddr = acc_q;
				state_d = rc4_pkg::ST_PR_XOR;
			end
			rc4_pkg::ST_PR_XOR: begin
				state_d = rc4_pkg::ST_DONE;
			end
			rc4_pkg::ST_DONE: begin
				if (res.ready) begin
					state_d = rc4_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rc4_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rc4_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			kpos_q <= '0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			case (state_q)
				rc4_pkg::ST_IDLE: begin
					if (accept && (cmd.kind == rc4_pkg::KIND_SCHED)) begin
						cnt_q <= '0;
						kpos_q <= '0;
					end
				end
				rc4_pkg::ST_INIT: begin
					cnt_q <= cnt_q + 8'd1;
				end
				rc4_pkg::ST_KS_WR_A: begin
					cnt_q <= cnt_q + 8'd1;
					kpos_q <= (kpos_q == kpos_last) ? '0 : KEY_AW'(kpos_q + 1'b1);
					if (cnt_q == 8'hff) begin
						i_q <= '0;
						j_q <= '0;
					end
				end
				rc4_pkg::ST_PR_I: begin
					i_q <= sum;
				end
				rc4_pkg::ST_PR_J: begin
					j_q <= sum;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rc4_pkg::ST_IDLE: begin
				acc_q <= '0;
				din_q <= cmd.data_in;
				last_q <= cmd.last_byte;
			end
			rc4_pkg::ST_KS_ACC: begin
				acc_q <= sum;
				pa_q <= perm_rdata;
			end
			rc4_pkg::ST_KS_WR_A: begin
				res_data_q <= '0;
				res_done_q <= 1'b1;
				res_last_q <= 1'b0;
			end
			rc4_pkg::ST_PR_J: begin
				pa_q <= perm_rdata;
			end
			rc4_pkg::ST_PR_WR_I: begin
				pb_q <= perm_rdata;
			end
			rc4_pkg::ST_PR_WR_J: begin
				acc_q <= sum;
			end
			rc4_pkg::ST_PR_XOR: begin
				res_data_q <= din_q ^ perm_rdata;
				res_done_q <= 1'b0;
				res_last_q <= last_q;
			end
			default: begin
			end
		endcase
	end

	a_no_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ready && res.valid))
		else $error("input ready while a result beat is pending");

	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready |=> cmd.ready)
		else $error("engine not ready after result beat");

	a_done_beat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.schedule_done |-> (res.data_out == 8'd0) && !res.last_out)
		else $error("schedule done beat carries data");

	a_done_indices_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.schedule_done |-> (i_q == 8'd0) && (j_q == 8'd0))
		else $error("indices not cleared after schedule");

	a_key_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> (state_q == rc4_pkg::ST_IDLE) && !perm_req.we)
		else $error("key write outside idle");

endmodule
